[sv/lph_pkg.sv]
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned VAL_IN_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[sv/lph_mod.sv]
// Start slot unit: reduces the key hash modulo the slot count.
`timescale 1ns / 1ps
`default_nettype none

module lph_mod #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lph_pkg::HASH_W-1:0] hash,
  output logic                            done,
  output logic [AW-1:0]                   idx
);

  generate
    if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
      logic [AW-1:0] idx_r;
      logic          done_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          idx_r <= hash[AW-1:0];
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end else begin : g_recip
      localparam int unsigned HW = lph_pkg::HASH_W;
      localparam int unsigned QW = HW + 1 - AW;
      localparam int unsigned PW = 2 * HW + 2;
      localparam longint unsigned RECIP_L = ((64'd1 << (HW + AW)) / SLOTS) + 64'd1;
      localparam logic [HW:0]   RECIP    = (HW+1)'(RECIP_L);
      localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);

      logic [PW-1:0] prod_r;
      logic [AW-1:0] hash_lo_r;
      logic [AW-1:0] idx_r;
      logic          mul_r;
      logic          done_r;
      logic [QW-1:0] quot;
      logic [AW-1:0] back;

      assign quot = prod_r[HW+AW +: QW];
      assign back = quot[AW-1:0] * SLOTS_LO;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mul_r  <= 1'b0;
          done_r <= 1'b0;
        end else begin
          mul_r  <= start;
          done_r <= mul_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          prod_r    <= PW'(hash) * PW'(RECIP);
          hash_lo_r <= hash[AW-1:0];
        end
        if (mul_r) begin
          idx_r <= hash_lo_r - back;
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end
  endgenerate

endmodule

`default_nettype wire

[sv/lph_mem.sv]
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lph_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 66,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/linear_probe_hash_table.sv]
// Top level: linear probing hash table with tombstones and its probe sequencer.
// Probing reads one slot per cycle through the one read port of the slot memory; when
// SLOTS is not a power of two the hash reduction adds a product register before the
// index register. Requests that miss at once skip the hash and probe states.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: a clearing pass empties every slot of the slot memory, in_stall high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lph_pkg::OP_W-1:0]     in_operation,
  input  wire logic [lph_pkg::KEY_IN_W-1:0] in_key,
  input  wire logic [lph_pkg::HASH_W-1:0]   in_key_hash,
  input  wire logic [lph_pkg::VAL_IN_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lph_pkg::ST_W-1:0]          out_status,
  output logic                              out_found,
  output logic [lph_pkg::VAL_IN_W-1:0]      out_read_value
);

  localparam int unsigned KW = (KEY_BITS < lph_pkg::KEY_IN_W) ? KEY_BITS : lph_pkg::KEY_IN_W;
  localparam int unsigned VW = (VALUE_BITS < lph_pkg::VAL_IN_W) ? VALUE_BITS
                                                                : lph_pkg::VAL_IN_W;
  localparam int unsigned OUT_W    = lph_pkg::VAL_IN_W;
  localparam int unsigned AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW       = $clog2(SLOTS + 1);
  localparam int unsigned EW       = 2 + KW + VW;
  localparam int unsigned LOAD_MAX = (3 * SLOTS) / 4;

  lph_pkg::state_t  state_r, state_nxt;
  logic [lph_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [VW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]    chk_n_r, chk_n_nxt;
  logic             pend_r, pend_nxt;
  logic             tomb_ok_r, tomb_ok_nxt;
  logic [AW-1:0]    tomb_idx_r, tomb_idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  lph_pkg::status_t res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [VW-1:0]    res_rv_r, res_rv_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [EW-1:0]    wr_data_r, wr_data_nxt;
  logic             cnt_inc_r, cnt_inc_nxt;
  logic             out_valid_r, out_valid_nxt;
  lph_pkg::status_t out_status_r, out_status_nxt;
  logic             out_found_r, out_found_nxt;
  logic [VW-1:0]    out_rv_r, out_rv_nxt;

  logic          in_accept;
  logic          quick_miss;
  logic          load;
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_idx;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rd_data;
  logic          e_used, e_live, e_match, e_empty, e_last, stop;
  logic [KW-1:0] e_key;
  logic [VW-1:0] e_val;
  logic [AW-1:0] idx_inc;

  function automatic logic op_t_is_lookup(input logic [lph_pkg::OP_W-1:0] op);
    return (op == lph_pkg::OP_GET) || (op == lph_pkg::OP_REMOVE);
  endfunction

  lph_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .hash  (in_key_hash),
    .done  (mod_done),
    .idx   (mod_idx)
  );

  lph_mem #(.DEPTH(SLOTS), .WIDTH(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign e_used  = rd_data[EW-1];
  assign e_live  = rd_data[EW-2];
  assign e_key   = rd_data[KW+VW-1:VW];
  assign e_val   = rd_data[VW-1:0];
  assign e_match = e_used && (e_key == key_r);
  assign e_empty = !e_used;
  assign e_last  = (chk_n_r == AW'(SLOTS - 1));
  assign stop    = (state_r == lph_pkg::S_PROBE) && pend_r && (e_match || e_empty || e_last);
  assign idx_inc = (idx_r == AW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;

  assign quick_miss = (op_t_is_lookup(in_operation) && (cnt_r == '0)) ||
                      !(op_t_is_lookup(in_operation) ||
                        (in_operation == lph_pkg::OP_SET));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lph_pkg::S_CLEAR: begin
        if (clr_idx_r == AW'(SLOTS - 1)) begin
          state_nxt = lph_pkg::S_IDLE;
        end
      end
      lph_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = quick_miss ? lph_pkg::S_DONE : lph_pkg::S_HASH;
        end
      end
      lph_pkg::S_HASH: begin
        if (mod_done) begin
          state_nxt = lph_pkg::S_PROBE;
        end
      end
      lph_pkg::S_PROBE: begin
        if (stop) begin
          state_nxt = lph_pkg::S_DONE;
        end
      end
      lph_pkg::S_DONE: begin
        if (load) begin
          state_nxt = lph_pkg::S_IDLE;
        end
      end
      default: state_nxt = lph_pkg::S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != lph_pkg::S_IDLE);
    in_accept = in_valid && !in_stall;
    mod_start = in_accept && !quick_miss;
    load      = (state_r == lph_pkg::S_DONE) && (!out_valid_r || !out_stall);
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = wr_data_r;
    if (state_r == lph_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (load && wr_pend_r) begin
      mem_we = 1'b1;
    end
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_n_nxt      = chk_n_r;
    pend_nxt       = pend_r;
    tomb_ok_nxt    = tomb_ok_r;
    tomb_idx_nxt   = tomb_idx_r;
    cnt_nxt        = cnt_r;
    clr_idx_nxt    = clr_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_rv_nxt     = res_rv_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    cnt_inc_nxt    = cnt_inc_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_rv_nxt     = out_rv_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (state_r == lph_pkg::S_CLEAR) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
    end

    if (in_accept) begin
      op_nxt         = in_operation;
      key_nxt        = in_key[KW-1:0];
      val_nxt        = in_value[VW-1:0];
      res_status_nxt = lph_pkg::ST_MISS;
      res_found_nxt  = 1'b0;
      res_rv_nxt     = '0;
      wr_pend_nxt    = 1'b0;
      cnt_inc_nxt    = 1'b0;
    end

    if ((state_r == lph_pkg::S_HASH) && mod_done) begin
      idx_nxt     = mod_idx;
      pend_nxt    = 1'b0;
      chk_n_nxt   = '0;
      tomb_ok_nxt = 1'b0;
    end

    if (state_r == lph_pkg::S_PROBE) begin
      idx_nxt     = idx_inc;
      chk_idx_nxt = idx_r;
      pend_nxt    = 1'b1;
      if (pend_r) begin
        chk_n_nxt = chk_n_r + 1'b1;
        if (e_used && !e_live) begin
          tomb_ok_nxt  = 1'b1;
          tomb_idx_nxt = chk_idx_r;
        end
      end
      if (stop) begin
        wr_addr_nxt = chk_idx_r;
        wr_data_nxt = {2'b11, key_r, val_r};
        priority case (op_r)
          lph_pkg::OP_SET: begin
            if (e_match) begin
              res_status_nxt = lph_pkg::ST_OK;
              wr_pend_nxt    = 1'b1;
            end else if (e_empty && tomb_ok_r) begin
              res_status_nxt = lph_pkg::ST_OK;
              wr_pend_nxt    = 1'b1;
              wr_addr_nxt    = tomb_idx_r;
            end else if (e_empty && (cnt_r < CW'(LOAD_MAX))) begin
              res_status_nxt = lph_pkg::ST_OK;
              wr_pend_nxt    = 1'b1;
              cnt_inc_nxt    = 1'b1;
            end else begin
              res_status_nxt = lph_pkg::ST_FULL;
            end
          end
          lph_pkg::OP_GET, lph_pkg::OP_REMOVE: begin
            if (e_match && e_live) begin
              res_status_nxt = lph_pkg::ST_OK;
              if (op_r == lph_pkg::OP_GET) begin
                res_found_nxt = 1'b1;
                res_rv_nxt    = e_val;
              end else begin
                wr_pend_nxt = 1'b1;
                wr_data_nxt = {2'b10, e_key, e_val};
              end
            end else if (e_match || e_empty) begin
              res_status_nxt = lph_pkg::ST_MISS;
            end else begin
              res_status_nxt = lph_pkg::ST_FULL;
            end
          end
          default: res_status_nxt = lph_pkg::ST_MISS;
        endcase
      end
    end

    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_found_nxt  = res_found_r;
      out_rv_nxt     = res_rv_r;
      if (cnt_inc_r) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lph_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    chk_n_r      <= chk_n_nxt;
    tomb_ok_r    <= tomb_ok_nxt;
    tomb_idx_r   <= tomb_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_rv_r     <= res_rv_nxt;
    wr_pend_r    <= wr_pend_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_data_r    <= wr_data_nxt;
    cnt_inc_r    <= cnt_inc_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_rv_r     <= out_rv_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_read_value = OUT_W'(out_rv_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LOAD_MAX))
    else $error("occupied count above load limit");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load && cnt_inc_r) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("occupied count did not advance on fresh insert");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == lph_pkg::S_CLEAR) || (state_r == lph_pkg::S_DONE)))
    else $error("slot write outside clear or commit");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == lph_pkg::ST_OK))
    else $error("found flag without ok status");

endmodule

`default_nettype wire
